@@ design/binary_to_decimal_digits_macros.svh @@
// Assertion macros for binary_to_decimal_digits.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef BINARY_TO_DECIMAL_DIGITS_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_MACROS_SVH

// Same-cycle implication.
`define B2D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b2d assertion failed");

// Next-cycle implication.
`define B2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b2d assertion failed");

`endif

@@ design/b2d_pkg.sv @@
// Package for binary_to_decimal_digits: sizes, constants and the
// command/status types between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package b2d_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 20;
    localparam int BCD_WIDTH   = MAX_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic load;
        logic shift;
        logic scan;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bits_done;
        logic last;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

@@ design/b2d_datapath.sv @@
// Datapath: input shift register, BCD register with add-3 adjust,
// bit counter and digit index. Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [63:0]          value,
    input  b2d_pkg::ctrl_cmd_t   cmd,
    output b2d_pkg::dp_status_t  status,
    output logic [5:0]           digit_char,
    output logic                 last_digit
);
    import b2d_pkg::*;

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_adj;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [DIG_IDX_W-1:0]   idx_reg;
    logic [DIG_IDX_W-1:0]   top_idx;
    logic [3:0]             cur_digit;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // highest nonzero digit, zero value gives index 0
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                top_idx = DIG_IDX_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= value[VALUE_WIDTH-1:0];
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            val_reg <= {val_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_WIDTH-2:0], val_reg[VALUE_WIDTH-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
                bit_cnt_reg <= BIT_CNT_W'(VALUE_WIDTH - 1);
            else if (cmd.shift)
                bit_cnt_reg <= bit_cnt_reg - 1'b1;

            if (cmd.scan)
                idx_reg <= top_idx;
            else if (cmd.emit)
                idx_reg <= idx_reg - 1'b1;
        end
    end

    assign cur_digit        = bcd_reg[idx_reg*4 +: 4];
    assign digit_char       = ASCII_ZERO + {2'b00, cur_digit};
    assign last_digit       = (idx_reg == '0);
    assign status.bits_done = (bit_cnt_reg == '0);
    assign status.last      = (idx_reg == '0);

endmodule

@@ design/b2d_ctrl.sv @@
// Controller state machine: sequences load, shift, scan and digit output.
// Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  b2d_pkg::dp_status_t  status,
    output b2d_pkg::ctrl_cmd_t   cmd,
    output logic                 busy
);
    import b2d_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.bits_done)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ design/binary_to_decimal_digits.sv @@
// Binary to decimal digits, top level: controller plus datapath.
// Depends on b2d_pkg, b2d_ctrl, b2d_datapath and the macros header.
//
// A word is taken when start is high and busy is low. The 64-bit value is
// converted by bit-serial double dabble, one bit per cycle, followed by the
// scan state, which locates the leading digit; then the n digits (1 to 20)
// leave one per cycle, most significant first, each marked by digit_valid
// for a single cycle, the last with last_digit set. The receiver cannot
// stall: digits must be taken as they appear. busy falls the cycle after
// the last digit.
`timescale 1ns / 1ps

`include "binary_to_decimal_digits_macros.svh"

module binary_to_decimal_digits (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value,
    output logic        digit_valid,
    output logic [5:0]  digit_char,
    output logic        last_digit
);
    import b2d_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    b2d_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    b2d_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    assign digit_valid = cmd.emit;

    `B2D_ASSERT_NOW(a_digit_range, digit_valid, (digit_char >= 6'd48) && (digit_char <= 6'd57))
    `B2D_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !digit_valid)
    `B2D_ASSERT_NEXT(a_last_ends, digit_valid && last_digit, !digit_valid && !busy)
    `B2D_ASSERT_NOW(a_valid_busy, digit_valid, busy)

endmodule
